/* rtl/core/huffman_bit_decoder_defines.svh */
// ----------------------------------------------------------------------------
// huffman_bit_decoder_defines.svh
// Assertion macros for the Huffman bit decoder.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_DECODER_DEFINES_SVH
`define HUFFMAN_BIT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HBD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define HBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HBD_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define HBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/hbd_pkg.sv */
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared field widths, command codes and types of the Huffman bit decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int CMD_W = 2;
  localparam int IDX_W = 9;
  localparam int SYM_W = 8;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DECODE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
  } sym_push_t;

endpackage

/* rtl/core/hbd_if.sv */
// ----------------------------------------------------------------------------
// hbd_if
// Valid/ready stream interfaces for command input and symbol output.
// ----------------------------------------------------------------------------
interface hbd_in_if
  import hbd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic             is_leaf;
  logic [SYM_W-1:0] leaf_symbol;
  logic             code_bit;

  modport source (
    output valid, cmd, node_index, left_child, right_child, is_leaf, leaf_symbol, code_bit,
    input  ready
  );
  modport sink (
    input  valid, cmd, node_index, left_child, right_child, is_leaf, leaf_symbol, code_bit,
    output ready
  );
endinterface

interface hbd_out_if
  import hbd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] decoded_symbol;

  modport source (output valid, decoded_symbol, input ready);
  modport sink (input valid, decoded_symbol, output ready);
endinterface

/* rtl/core/hbd_ram.sv */
// ----------------------------------------------------------------------------
// hbd_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hbd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/core/hbd_out_stage.sv */
// ----------------------------------------------------------------------------
// hbd_out_stage
// Output register holding one decoded symbol until the sink takes it.
// ----------------------------------------------------------------------------
module hbd_out_stage
  import hbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sym_push_t push_i,
  output logic      free_o,
  hbd_out_if.source out_o
);

  logic             valid_q;
  logic [SYM_W-1:0] symbol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.valid) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      symbol_q <= push_i.symbol;
    end
  end

  assign free_o               = !valid_q || out_o.ready;
  assign out_o.valid          = valid_q;
  assign out_o.decoded_symbol = symbol_q;

endmodule

/* rtl/core/huffman_bit_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_bit_decoder
// Tree-walk Huffman decoder: one code bit per transaction, node table in RAM.
// ----------------------------------------------------------------------------
// The code tree lives in a synchronous node RAM with one write and one read
// port; the node under the walk is cached in registers. A decode bit that
// lands on an inner node issues the child read, then latches the child; one
// that reaches a leaf pushes its symbol while the RAM read reloads the root
// node. A bit taken while the cached node is itself a leaf puts its symbol
// out at once, then reloads the root. Node writes keep the block ready;
// restarts reload the root. After reset the block loads the node at slot 0
// before it is ready. Decode bits wait for room in the output register; node
// writes and restarts do not. Reading a node never written is undefined.
// ----------------------------------------------------------------------------
`include "huffman_bit_decoder_defines.svh"

module huffman_bit_decoder
  import hbd_pkg::*;
#(
  parameter int NODE_SLOTS  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_wdata_i,
  hbd_in_if.sink           in_i,
  hbd_out_if.source        out_o
);

  localparam int AW = $clog2(NODE_SLOTS);

  typedef struct packed {
    logic [IDX_W-1:0]       left;
    logic [IDX_W-1:0]       right;
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] symbol;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    ST_FETCH,
    ST_FILL,
    ST_READY,
    ST_WAIT
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] root_q;
  logic [IDX_W-1:0] walk_q, walk_d;
  node_t            cur_q, cur_d;
  logic             rd_oor_q, rd_oor_d;

  logic              in_rdy, in_acc, out_free;
  logic              is_write, is_decode, is_restart;
  logic              wr_in_range;
  logic [IDX_W-1:0]  child;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  rd_idx;
  logic [NODE_W-1:0] ram_rdata;
  node_t             wr_node, rd_node;
  sym_push_t         push;

  assign is_write   = in_i.cmd == CMD_WRITE;
  assign is_decode  = in_i.cmd == CMD_DECODE;
  assign is_restart = in_i.cmd == CMD_RESTART;

  assign in_rdy     = (state_q == ST_READY) && (!is_decode || out_free);
  assign in_i.ready = in_rdy;
  assign in_acc     = in_i.valid && in_rdy;

  assign child       = in_i.code_bit ? cur_q.right : cur_q.left;
  assign wr_in_range = 32'(in_i.node_index) < NODE_SLOTS;

  assign wr_node.left   = in_i.left_child;
  assign wr_node.right  = in_i.right_child;
  assign wr_node.leaf   = in_i.is_leaf;
  assign wr_node.symbol = SYMBOL_BITS'(in_i.leaf_symbol);

  assign ram_we  = in_acc && is_write && wr_in_range;
  assign rd_node = rd_oor_q ? '0 : node_t'(ram_rdata);

  always_comb begin
    ram_re = 1'b0;
    rd_idx = root_q;
    unique case (state_q)
      ST_FETCH: begin
        ram_re = 1'b1;
        rd_idx = walk_q;
      end
      ST_WAIT: begin
        ram_re = 1'b1;
        rd_idx = root_q;
      end
      ST_READY: begin
        if (in_acc && is_decode && !cur_q.leaf) begin
          ram_re = 1'b1;
          rd_idx = child;
        end else if (in_acc && (is_restart || is_decode)) begin
          ram_re = 1'b1;
          rd_idx = root_q;
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  assign rd_oor_d = !(32'(rd_idx) < NODE_SLOTS);

  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    cur_d       = cur_q;
    push.valid  = 1'b0;
    push.symbol = SYM_W'(cur_q.symbol);
    unique case (state_q)
      ST_FETCH: begin
        state_d = ST_FILL;
      end
      ST_FILL: begin
        cur_d   = rd_node;
        state_d = ST_READY;
      end
      ST_READY: begin
        if (in_acc) begin
          priority if (is_write) begin
            if (wr_in_range && (in_i.node_index == walk_q)) begin
              cur_d = wr_node;
            end
          end else if (is_restart) begin
            walk_d  = root_q;
            state_d = ST_FILL;
          end else if (is_decode) begin
            if (cur_q.leaf) begin
              push.valid = 1'b1;
              walk_d     = root_q;
              state_d    = ST_FILL;
            end else begin
              walk_d  = child;
              state_d = ST_WAIT;
            end
          end else begin
            state_d = ST_READY;
          end
        end
      end
      ST_WAIT: begin
        if (rd_node.leaf) begin
          push.valid  = 1'b1;
          push.symbol = SYM_W'(rd_node.symbol);
          walk_d      = root_q;
          state_d     = ST_FILL;
        end else begin
          cur_d   = rd_node;
          state_d = ST_READY;
        end
      end
      default: begin
        state_d = ST_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FETCH;
      walk_q   <= '0;
      root_q   <= '0;
      rd_oor_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_q   <= walk_d;
      rd_oor_q <= ram_re ? rd_oor_d : rd_oor_q;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  hbd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_SLOTS)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_i.node_index)),
    .wdata_i (wr_node),
    .re_i    (ram_re),
    .raddr_i (AW'(rd_idx)),
    .rdata_o (ram_rdata)
  );

  hbd_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .free_o (out_free),
    .out_o  (out_o)
  );

  `HBD_ASSERT_NOW(a_ready_only_cached, clk_i, rst_ni, in_i.ready, state_q == ST_READY)
  `HBD_ASSERT_NOW(a_push_has_room, clk_i, rst_ni, push.valid, !out_o.valid || out_o.ready)
  `HBD_ASSERT_NEXT(a_inner_step_waits, clk_i, rst_ni, in_acc && is_decode && !cur_q.leaf, state_q == ST_WAIT)
  `HBD_ASSERT_NEXT(a_leaf_reloads_root, clk_i, rst_ni, state_q == ST_WAIT && rd_node.leaf, state_q == ST_FILL && walk_q == root_q)

endmodule

/* sim/huffman_bit_decoder_checker.sv */
// ----------------------------------------------------------------------------
// huffman_bit_decoder_checker
// Watches the command and symbol streams of the Huffman bit decoder. Keeps a
// shadow node table, walk position and root register, predicts the symbol of
// every decode bit that lands on a leaf, and compares each symbol transaction
// with the oldest prediction in order.
// ----------------------------------------------------------------------------
module huffman_bit_decoder_checker
  import hbd_pkg::*;
#(
  parameter int SLOTS = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_wdata_i,
  hbd_in_if                in_mon,
  hbd_out_if               out_mon,
  output int               mismatches_o,
  output int               outstanding_o
);

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] symbol;
  } tree_node_t;

  tree_node_t       shadow_nodes [SLOTS];
  logic [IDX_W-1:0] walk_slot;
  logic [IDX_W-1:0] root_slot;
  logic [SYM_W-1:0] pending_symbols [$];
  int               mismatches;

  // One code bit through the shadow tree; returns 1 when a leaf is reached.
  function automatic bit follow_bit(input logic code_bit, output logic [SYM_W-1:0] sym);
    tree_node_t       here;
    tree_node_t       next_node;
    logic [IDX_W-1:0] child;
    here = shadow_nodes[walk_slot];
    sym  = '0;
    if (here.leaf) begin
      sym       = here.symbol;
      walk_slot = root_slot;
      return 1'b1;
    end
    child     = code_bit ? here.right : here.left;
    next_node = shadow_nodes[child];
    if (next_node.leaf) begin
      sym       = next_node.symbol;
      walk_slot = root_slot;
      return 1'b1;
    end
    walk_slot = child;
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] want;
    if (!rst_ni) begin
      walk_slot = '0;
      root_slot = '0;
      pending_symbols.delete();
      mismatches = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_symbols.size() == 0) begin
          $display("%0t: symbol mismatch: expected none, actual %02h",
                   $time, out_mon.decoded_symbol);
          mismatches++;
        end else begin
          want = pending_symbols.pop_front();
          if (out_mon.decoded_symbol !== want) begin
            $display("%0t: symbol mismatch: expected %02h, actual %02h",
                     $time, want, out_mon.decoded_symbol);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_WRITE: begin
            shadow_nodes[in_mon.node_index] = '{left:   in_mon.left_child,
                                                right:  in_mon.right_child,
                                                leaf:   in_mon.is_leaf,
                                                symbol: in_mon.leaf_symbol};
          end
          CMD_RESTART: begin
            walk_slot = root_slot;
          end
          CMD_DECODE: begin
            if (follow_bit(in_mon.code_bit, sym)) pending_symbols.push_back(sym);
          end
          default: ;
        endcase
      end
      if (cfg_we_i) root_slot = cfg_wdata_i;
      mismatches_o  <= mismatches;
      outstanding_o <= pending_symbols.size();
    end
  end

endmodule

/* sim/huffman_bit_decoder_test.sv */
// ----------------------------------------------------------------------------
// huffman_bit_decoder_test
// Top of the Huffman bit decoder testbench. Fills the whole node table, runs
// directed walks (extreme fields, one-leaf tree, node rewritten under the
// walk, unused command), then random phases of freshly grown trees with
// random code bits mixed with raw command noise, under several root slots.
// Both streams stall in random bursts; the checker gives the verdict input.
// ----------------------------------------------------------------------------
module huffman_bit_decoder_test;
  import hbd_pkg::*;

  localparam int               SLOTS        = 512;
  localparam int               RANDOM_ITEMS = 380;
  localparam int               PHASE_ITEMS  = 150;
  localparam int               CYCLE_LIMIT  = 300000;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_wdata;
  logic             quiet;
  int               mismatches;
  int               outstanding;
  int               cycles = 0;

  hbd_in_if  in_if ();
  hbd_out_if out_if ();

  huffman_bit_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if.sink),
    .out_o       (out_if.source)
  );

  huffman_bit_decoder_checker #(.SLOTS(SLOTS)) symbol_tracker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                      input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right,
                      input logic leaf, input logic [SYM_W-1:0] sym, input logic code_bit);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.node_index  <= idx;
    in_if.left_child  <= left;
    in_if.right_child <= right;
    in_if.is_leaf     <= leaf;
    in_if.leaf_symbol <= sym;
    in_if.code_bit    <= code_bit;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] left,
                            input logic [IDX_W-1:0] right, input logic leaf,
                            input logic [SYM_W-1:0] sym);
    send(CMD_WRITE, idx, left, right, leaf, sym, 1'($urandom_range(0, 1)));
  endtask

  task automatic decode_bit(input logic code_bit);
    send(CMD_DECODE, IDX_W'($urandom_range(0, SLOTS - 1)), IDX_W'($urandom_range(0, SLOTS - 1)),
         IDX_W'($urandom_range(0, SLOTS - 1)), 1'($urandom_range(0, 1)),
         SYM_W'($urandom_range(0, 255)), code_bit);
  endtask

  task automatic restart_walk();
    send(CMD_RESTART, IDX_W'($urandom_range(0, SLOTS - 1)), IDX_W'($urandom_range(0, SLOTS - 1)),
         IDX_W'($urandom_range(0, SLOTS - 1)), 1'($urandom_range(0, 1)),
         SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Stop sending and wait until every predicted symbol is out and the block settles.
  task automatic drain();
    in_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_root(input logic [IDX_W-1:0] slot);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= slot;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Grow a random full binary tree at top_slot over distinct slots.
  task automatic grow_tree(input logic [IDX_W-1:0] top_slot, output int writes);
    bit               taken [SLOTS];
    int               open_q [$];
    int               slot;
    int               inner;
    int               inner_cap;
    logic [IDX_W-1:0] kid [2];
    writes    = 0;
    inner     = 0;
    inner_cap = $urandom_range(0, 7);
    foreach (taken[i]) taken[i] = 1'b0;
    taken[top_slot] = 1'b1;
    open_q.push_back(top_slot);
    while (open_q.size() != 0) begin
      slot = open_q.pop_front();
      if (inner < inner_cap && (slot == top_slot || $urandom_range(0, 2) != 0)) begin
        for (int k = 0; k < 2; k++) begin
          do kid[k] = IDX_W'($urandom_range(0, SLOTS - 1)); while (taken[kid[k]]);
          taken[kid[k]] = 1'b1;
          open_q.push_back(kid[k]);
        end
        write_node(IDX_W'(slot), kid[0], kid[1], 1'b0, SYM_W'($urandom_range(0, 255)));
        inner++;
      end else begin
        write_node(IDX_W'(slot), IDX_W'($urandom_range(0, SLOTS - 1)),
                   IDX_W'($urandom_range(0, SLOTS - 1)), 1'b1,
                   SYM_W'($urandom_range(0, 255)));
      end
      writes++;
    end
  endtask

  initial begin
    int               sent;
    int               phase;
    int               phase_end;
    int               n;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] root;

    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_WRITE;
    in_if.node_index  = '0;
    in_if.left_child  = '0;
    in_if.right_child = '0;
    in_if.is_leaf     = 1'b0;
    in_if.leaf_symbol = '0;
    in_if.code_bit    = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    quiet             = 1'b0;
    rst_n             = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_root('0);
    // Every slot gets defined content before any walk.
    for (int s = 0; s < SLOTS; s++) begin
      write_node(IDX_W'(s), IDX_W'($urandom_range(0, SLOTS - 1)),
                 IDX_W'($urandom_range(0, SLOTS - 1)), 1'($urandom_range(0, 1)),
                 SYM_W'($urandom_range(0, 255)));
    end

    write_node(9'd0,   9'd1,   9'd511, 1'b0, 8'h81);
    write_node(9'd1,   9'd511, 9'd0,   1'b1, 8'h00);
    write_node(9'd511, 9'd2,   9'd3,   1'b0, 8'h7E);
    write_node(9'd2,   9'd0,   9'd0,   1'b1, 8'hFF);
    write_node(9'd3,   9'd511, 9'd511, 1'b1, 8'hA5);
    restart_walk();
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b1);
    // inner node turned into a leaf while the walk stands on it
    decode_bit(1'b1);
    write_node(9'd511, 9'd2, 9'd3, 1'b1, 8'h5A);
    decode_bit(1'b0);
    send(CMD_UNUSED, 9'd511, 9'd511, 9'd511, 1'b1, 8'hFF, 1'b1);
    // one-leaf tree
    write_node(9'd0, 9'd511, 9'd511, 1'b1, 8'h3C);
    restart_walk();
    decode_bit(1'b1);
    decode_bit(1'b0);
    decode_bit(1'b1);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0:       root = IDX_W'(SLOTS - 1);
        1:       root = '0;
        default: root = IDX_W'($urandom_range(0, SLOTS - 1));
      endcase
      set_root(root);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        quiet = (sent >= RANDOM_ITEMS - 100);
        if ($urandom_range(0, 9) < 7) begin
          grow_tree(root, n);
          sent += n;
          restart_walk();
          n = $urandom_range(8, 40);
          repeat (n) decode_bit(1'($urandom_range(0, 1)));
          sent += n + 1;
        end else begin
          repeat ($urandom_range(3, 15)) begin
            cmd = CMD_W'($urandom_range(0, 3));
            send(cmd, IDX_W'($urandom_range(0, SLOTS - 1)), IDX_W'($urandom_range(0, SLOTS - 1)),
                 IDX_W'($urandom_range(0, SLOTS - 1)), 1'($urandom_range(0, 1)),
                 SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            if (cmd != CMD_UNUSED) sent++;
          end
        end
      end
      phase++;
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/hbd_pkg.sv
rtl/core/hbd_if.sv
rtl/core/hbd_ram.sv
rtl/core/hbd_out_stage.sv
rtl/core/huffman_bit_decoder.sv
sim/huffman_bit_decoder_checker.sv
sim/huffman_bit_decoder_test.sv
